[rtl/assert_macros.svh]
// Assertion macros shared by the execute unit RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, switched off while reset is low.
`define AIE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define AIE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AIE_ASSERT(lbl, clk, rst_n, prop, msg)
`define AIE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/aie_pkg.sv]
// Shared types and constants of the accumulator execute unit.
// No dependencies; imported by the multiply/divide unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package aie_pkg;

    localparam int DATA_W = 64;
    localparam int IMM_W  = 32;
    localparam int IP_W   = 32;
    localparam int CMD_W  = 4;
    localparam int REG_W  = 4;

    // Stream widths: slave tdata = reg_index, immediate; master tdata = next_ip, dest_value
    localparam int S_TDATA_W = ((REG_W + IMM_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = ((IP_W + DATA_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 3;

    localparam logic [IP_W-1:0] MEM_LIMIT_RST = 32'd65536;

    localparam logic [DATA_W-1:0] MASK_B = 64'h0000_0000_0000_00FF;
    localparam logic [DATA_W-1:0] MASK_W = 64'h0000_0000_0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_D = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MASK_Q = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOP   = 4'd0,
        CMD_MOVI  = 4'd1,
        CMD_INC   = 4'd2,
        CMD_DEC   = 4'd3,
        CMD_ADD   = 4'd4,
        CMD_SUB   = 4'd5,
        CMD_MUL   = 4'd6,
        CMD_DIV   = 4'd7,
        CMD_BR    = 4'd8,
        CMD_MRO_B = 4'd9,
        CMD_MRO_W = 4'd10,
        CMD_MRO_D = 4'd11,
        CMD_MRO_Q = 4'd12,
        CMD_HALT  = 4'd13
    } t_cmd;

    // Request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic op_div;
    } t_md_req;

    // Response from the multiply/divide unit
    typedef struct packed {
        logic done;
    } t_md_rsp;

    function automatic logic [DATA_W-1:0] width_mask(t_cmd c);
        logic [DATA_W-1:0] m;
        case (c)
            CMD_MRO_B: m = MASK_B;
            CMD_MRO_W: m = MASK_W;
            CMD_MRO_D: m = MASK_D;
            default:   m = MASK_Q;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/accumulator_isa_execute_unit.sv]
// Top level of the accumulator execute unit: stream ports, sequencer, register file.
// Depends on aie_pkg, aie_ram, aie_muldiv and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Executes one instruction word at a time against a REG_COUNT x 64-bit register
// file and a 32-bit instruction pointer. The register file sits in a synchronous
// RAM read at acceptance, so the operand arrives in the next cycle; the new
// value is written back when the result word is loaded into the output register.
// Multiply (one shared 32x32 multiplier over three partial products) and
// divide (a restoring divider that yields one quotient bit per cycle) wait on the
// iterative unit between the execute and done states; the next word is taken in
// the cycle after the result is loaded. The result sits in an output register, so
// a new word is taken while it waits, and only the write-back stalls on a full
// output. A branch to address zero clears the whole register file through a row of
// per-entry valid flags, so reset needs no clearing pass. Register zero is never
// written and always reads zero. memory_limit is written on its own channel, which
// is always ready, and must only change while the unit is idle.
module accumulator_isa_execute_unit
    import aie_pkg::*;
#(
    parameter int REG_COUNT  = 16,
    parameter int INST_BYTES = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Instruction words
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [3:0] reg_index, [35:4] immediate
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // [3:0] command
    // Result words
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,  // [31:0] next_ip, [95:32] dest_value
    output logic      [M_TUSER_W-1:0] m_axis_tuser,  // [0] halted, [1] out_of_range,
                                                     // [2] divide_fault
    // memory_limit write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [IP_W-1:0]      i_cfg_data
);

    localparam int RF_AW = $clog2(REG_COUNT);
    localparam int IDX_W = ((RF_AW > REG_W) ? RF_AW : REG_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MD   = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [REG_W-1:0]  r_rd;
    logic [DATA_W-1:0] r_imm;
    logic [IP_W-1:0]   r_ip;
    logic [IP_W-1:0]   r_limit;
    logic [REG_COUNT-1:0] r_valid;

    // Results of the execute step, held until write-back
    logic [DATA_W-1:0] r_newval;
    logic              r_we;
    logic              r_clr;
    logic              r_dest_ok;
    logic [IP_W-1:0]   r_next_ip;
    logic              r_halt;
    logic              r_oor;
    logic              r_dfault;

    // Output register
    logic              r_o_valid;
    logic [IP_W-1:0]   r_o_ip;
    logic [DATA_W-1:0] r_o_dest;
    logic [M_TUSER_W-1:0] r_o_flags;

    logic              s_accept;
    logic              out_free;
    logic [IDX_W-1:0]  in_rd_ext;
    logic [RF_AW-1:0]  in_idx;
    logic [IDX_W-1:0]  rd_ext;
    logic [RF_AW-1:0]  rd_idx;
    logic              rd_ok;
    logic              rd_zero;
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;
    logic [DATA_W-1:0] cur;
    logic              imm_zero;
    logic              imm_one;
    logic [IP_W-1:0]   target;
    logic              is_br;
    logic [IP_W-1:0]   ip_base;

    logic [DATA_W-1:0] x_newval;
    logic              x_we;
    logic              x_dfault;
    logic              x_clr;
    logic [IP_W-1:0]   x_next_ip;
    logic              x_halt;
    logic              x_oor;

    t_md_req           md_req;
    t_md_rsp           md_rsp;
    logic [DATA_W-1:0] md_result;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_o_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Register numbers: widen so the bound check is exact for any REG_COUNT
    assign in_rd_ext = IDX_W'(s_axis_tdata[REG_W-1:0]);
    assign in_idx    = in_rd_ext[RF_AW-1:0];
    assign rd_ext    = IDX_W'(r_rd);
    assign rd_idx    = rd_ext[RF_AW-1:0];
    assign rd_ok     = rd_ext < IDX_W'(REG_COUNT);
    assign rd_zero   = (rd_idx == '0);

    // Entry cleared since its last write reads as zero
    assign cur      = (rd_ok && r_valid[rd_idx]) ? ram_rdata : '0;
    assign imm_zero = (r_imm == '0);
    assign imm_one  = (r_imm == DATA_W'(1));
    assign target   = cur[IP_W-1:0];
    assign is_br    = rd_ok && (r_cmd == CMD_BR);
    assign ip_base  = is_br ? target : r_ip;

    // Execute step: new value, write enable, pointer and flags
    always_comb begin
        case (r_cmd)
            CMD_MOVI: x_newval = r_imm;
            CMD_INC:  x_newval = cur + DATA_W'(1);
            CMD_DEC:  x_newval = cur - DATA_W'(1);
            CMD_ADD:  x_newval = cur + r_imm;
            CMD_SUB:  x_newval = cur - r_imm;
            CMD_MRO_B, CMD_MRO_W, CMD_MRO_D, CMD_MRO_Q: begin
                x_newval = imm_one ? (cur | width_mask(r_cmd))
                                   : (cur & ~width_mask(r_cmd));
            end
            default:  x_newval = cur;
        endcase

        x_dfault = rd_ok && (r_cmd == CMD_DIV) && imm_zero;

        case (r_cmd) inside
            [CMD_MOVI:CMD_DIV], [CMD_MRO_B:CMD_MRO_Q]: x_we = rd_ok && !rd_zero && !x_dfault;
            default:                                   x_we = 1'b0;
        endcase

        x_clr  = is_br && (target == '0);
        x_halt = 1'b0;
        x_oor  = 1'b0;
        if (r_cmd == CMD_NOP) begin
            x_next_ip = r_ip + IP_W'(INST_BYTES);
        end else if (r_cmd == CMD_HALT) begin
            x_halt    = 1'b1;
            x_next_ip = r_ip;
        end else if (ip_base >= r_limit) begin
            x_oor     = 1'b1;
            x_next_ip = ip_base;
        end else begin
            x_next_ip = ip_base + IP_W'(INST_BYTES);
        end
    end

    // Hand multiply and a valid divide to the iterative unit
    assign md_req.start  = (r_state == S_EXEC) && x_we &&
                           ((r_cmd == CMD_MUL) || (r_cmd == CMD_DIV));
    assign md_req.op_div = (r_cmd == CMD_DIV);

    aie_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_opa    (cur),
        .i_opb    (r_imm),
        .o_rsp    (md_rsp),
        .o_result (md_result)
    );

    // Write back together with the result word
    assign ram_we = (r_state == S_DONE) && out_free && r_we;

    aie_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (rd_idx),
        .i_wdata (r_newval),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ip      <= '0;
            r_limit   <= MEM_LIMIT_RST;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            // Drop the result word once taken
            if (r_o_valid && m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_cmd   <= t_cmd'(s_axis_tuser[CMD_W-1:0]);
                        r_rd    <= s_axis_tdata[REG_W-1:0];
                        r_imm   <= {{(DATA_W - IMM_W){s_axis_tdata[REG_W+IMM_W-1]}},
                                    s_axis_tdata[REG_W+IMM_W-1:REG_W]};
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_newval  <= x_newval;
                    r_we      <= x_we;
                    r_clr     <= x_clr;
                    r_dest_ok <= rd_ok && !rd_zero && !x_clr;
                    r_next_ip <= x_next_ip;
                    r_halt    <= x_halt;
                    r_oor     <= x_oor;
                    r_dfault  <= x_dfault;
                    r_state   <= md_req.start ? S_MD : S_DONE;
                end
                S_MD: begin
                    // Hold until the unit finishes
                    if (md_rsp.done) begin
                        r_newval <= md_result;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Advance only when the output register is free
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_ip    <= r_next_ip;
                        r_o_dest  <= r_dest_ok ? r_newval : '0;
                        r_o_flags <= {r_dfault, r_oor, r_halt};
                        r_ip      <= r_next_ip;
                        if (r_clr) begin
                            r_valid <= '0;
                        end else if (r_we) begin
                            r_valid[rd_idx] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_o_dest, r_o_ip});
    assign m_axis_tuser  = r_o_flags;

    `AIE_ASSERT(a_no_r0_write, i_clk, i_rst_n, ram_we |-> (rd_idx != '0), "register zero written")
    `AIE_ASSERT(a_fault_no_write, i_clk, i_rst_n, ((r_state == S_DONE) && r_dfault) |-> !r_we, "write after divide fault")
    `AIE_ASSERT(a_md_done_in_wait, i_clk, i_rst_n, md_rsp.done |-> (r_state == S_MD), "stray multiply/divide done")
    `AIE_ASSERT(a_accept_to_exec, i_clk, i_rst_n, s_accept |=> (r_state == S_EXEC), "accepted word not executed")
    `AIE_ASSERT(a_flags_exclusive, i_clk, i_rst_n, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]), "halt with out of range")

endmodule

`default_nettype wire

[rtl/aie_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the register file of the execute unit.
`timescale 1ns / 1ps
`default_nettype none

module aie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/aie_muldiv.sv]
// Iterative 64-bit multiply (three 32x32 partial products) and restoring divide.
// Depends on aie_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aie_muldiv
    import aie_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_md_req           i_req,
    input  wire logic [DATA_W-1:0] i_opa,
    input  wire logic [DATA_W-1:0] i_opb,
    output t_md_rsp                o_rsp,
    output logic      [DATA_W-1:0] o_result
);

    localparam int HALF  = DATA_W / 2;
    localparam int CNT_W = $clog2(DATA_W);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } t_md_state;

    t_md_state         r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic              r_op_div;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;   // product, or remainder while dividing
    logic [DATA_W-1:0] r_q;     // dividend shifting out, quotient shifting in

    logic [HALF-1:0]   mul_x;
    logic [HALF-1:0]   mul_y;
    logic [DATA_W:0]   trial;

    // Select the partial product for this step
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                mul_x = r_a[HALF-1:0];
                mul_y = r_b[HALF-1:0];
            end
            2'd1: begin
                mul_x = r_a[HALF-1:0];
                mul_y = r_b[DATA_W-1:HALF];
            end
            2'd2: begin
                mul_x = r_a[DATA_W-1:HALF];
                mul_y = r_b[HALF-1:0];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign trial = {r_acc, r_q[DATA_W-1]} - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MD_IDLE: begin
                    if (i_req.start) begin
                        r_op_div <= i_req.op_div;
                        r_b      <= i_opb;
                        r_cnt    <= '0;
                        if (i_req.op_div) begin
                            r_acc   <= '0;
                            r_q     <= i_opa;
                            r_state <= MD_DIV;
                        end else begin
                            r_a     <= i_opa;
                            r_state <= MD_MUL;
                        end
                    end
                end
                MD_MUL: begin
                    r_prod <= mul_x * mul_y;
                    if (r_cnt == CNT_W'(1)) begin
                        r_acc <= r_prod;
                    end else if (r_cnt != '0) begin
                        r_acc <= r_acc + {r_prod[HALF-1:0], {HALF{1'b0}}};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(3)) begin
                        r_done  <= 1'b1;
                        r_state <= MD_IDLE;
                    end
                end
                MD_DIV: begin
                    if (!trial[DATA_W]) begin
                        r_acc <= trial[DATA_W-1:0];
                        r_q   <= {r_q[DATA_W-2:0], 1'b1};
                    end else begin
                        r_acc <= {r_acc[DATA_W-2:0], r_q[DATA_W-1]};
                        r_q   <= {r_q[DATA_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DATA_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= MD_IDLE;
                    end
                end
                default: begin
                    r_state <= MD_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_result   = r_op_div ? r_q : r_acc;

    `AIE_ASSERT(a_md_no_early_done, i_clk, i_rst_n, i_req.start |=> !r_done, "done too early")
    `AIE_ASSERT(a_md_done_idle, i_clk, i_rst_n, r_done |-> (r_state == MD_IDLE), "busy after done")
    `AIE_ASSERT(a_md_div_nonzero, i_clk, i_rst_n, (i_req.start && i_req.op_div) |-> (i_opb != '0), "zero divisor started")

endmodule

`default_nettype wire
